// ===== hdl/hwg_pkg.sv =====
// Shared widths, fixed-point constants and register codes for the Hamming window generator.
`default_nettype none

package hwg_pkg;

  // Window geometry
  localparam int MAX_LENGTH     = 4096;
  localparam int MIN_LENGTH     = 2;
  localparam int RESET_LENGTH   = 256;
  localparam int LEN_W          = 13;
  localparam int IDX_W          = 12;

  // Output format
  localparam int FRAC_BITS      = 24;
  localparam int COEF_W         = FRAC_BITS + 1;
  localparam logic [COEF_W-1:0] COEF_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  // Configuration port
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LENGTH = 2'd0,
    REG_NORMALIZE     = 2'd1
  } cfg_reg_t;

  // Internal Q30 arithmetic
  localparam int Q_W                   = 30;
  localparam logic [Q_W:0]   Q30_ONE     = {1'b1, {Q_W{1'b0}}};
  localparam logic [32:0]    HALF_PI_Q32 = 33'd6746518852;
  localparam logic [Q_W-1:0] COEF_A      = 30'd579820585;   // 0.54
  localparam logic [28:0]    COEF_B      = 29'd493921239;   // 0.46

  // Taylor series, Horner form, six steps per lane
  localparam int SERIES_STEPS = 6;
  localparam int unsigned COS_DIV [SERIES_STEPS] = '{132, 90, 56, 30, 12, 2};
  localparam int unsigned SIN_DIV [SERIES_STEPS] = '{156, 110, 72, 42, 20, 6};

  // Reciprocal unit: 1/sum in Q3.29 from 2^59/sum
  localparam int NORM_SHIFT = 59;
  localparam int DIV_W      = NORM_SHIFT + 1;
  localparam int SUM_W      = $clog2(64'(COEF_A) * 64'(MAX_LENGTH) + 64'd1);

endpackage

`default_nettype wire

// ===== hdl/hwg_if.sv =====
// Valid/ready stream interfaces for sample indexes in and window coefficients out.
`default_nettype none

interface hwg_in_if;
  import hwg_pkg::*;

  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] sample_index;

  modport source (output valid, output sample_index, input ready);
  modport sink   (input valid, input sample_index, output ready);
endinterface

interface hwg_out_if;
  import hwg_pkg::*;

  logic              valid;
  logic              ready;
  logic [COEF_W-1:0] coefficient;
  logic              index_out_of_range;

  modport source (output valid, output coefficient, output index_out_of_range, input ready);
  modport sink   (input valid, input coefficient, input index_out_of_range, output ready);
endinterface

`default_nettype wire

// ===== hdl/hamming_window_generator.sv =====
// Hamming window generator top level: 21-stage coefficient pipeline and reciprocal unit.
// Throughput: one word per clock unless out_word stalls or a reciprocal rebuild is running.
// Reset (rst_n low, synchronous): length 256, normalize off, pipeline emptied.
// After reset and after each write to a known register index the shared divider rebuilds both
// reciprocals, one quotient bit per cycle; in_word.ready stays low meanwhile.
`default_nettype none

module hamming_window_generator (
  input  logic                           clk,
  input  logic                           rst_n,
  hwg_in_if.sink                         in_word,
  hwg_out_if.source                      out_word,
  input  logic                           cfg_we,
  input  logic [hwg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hwg_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import hwg_pkg::*;

  // ------------------------------------------------------------------
  // Pipeline stage map
  //   0      index register, range check
  //   1      phase = index * phase_step (mod 2^32)
  //   2      octant fold, angle in Q30 radians
  //   3      angle squared
  //   4..15  six Horner steps per lane, each a multiply stage then a
  //          divide-by-constant stage (reciprocal multiply)
  //   16     sin = x * sin series
  //   17     quadrant select, 0.46 * |cos|
  //   18     0.54 -/+ product, clamp at 1.0
  //   19     optional normalize by 1/sum
  //   20     Q30 -> Q1.24 rounding, out-of-range forcing (output register)
  // ------------------------------------------------------------------
  localparam int ST_IN    = 0;
  localparam int ST_PHASE = 1;
  localparam int ST_ANGLE = 2;
  localparam int ST_SQ    = 3;
  localparam int ST_SER0  = 4;
  localparam int ST_SIN   = ST_SER0 + 2 * SERIES_STEPS;
  localparam int ST_MAG   = ST_SIN + 1;
  localparam int ST_WIN   = ST_MAG + 1;
  localparam int ST_NORM  = ST_WIN + 1;
  localparam int ST_OUT   = ST_NORM + 1;
  localparam int NSTG     = ST_OUT + 1;

  // Output rounding from Q30 down (or up) to FRAC_BITS
  localparam int DN_SH    = (FRAC_BITS < Q_W) ? (Q_W - FRAC_BITS) : 0;
  localparam int UP_SH    = (FRAC_BITS > Q_W) ? (FRAC_BITS - Q_W) : 0;
  localparam int FRAC_RND = (2 ** DN_SH) / 2;

  localparam int CNT_W    = $clog2(DIV_W);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_W - 1);
  localparam logic [SUM_W-1:0] SUM_TWO  = SUM_W'(2 * (64'(COEF_A) - 64'(COEF_B)));

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_PHASE = 3'b010,
    S_NORM  = 3'b100
  } seq_state_t;

  // Control carried alongside each word
  typedef struct packed {
    logic           oor;
    logic [1:0]     quad;
    logic           swap;
    logic [Q_W-1:0] ang;
    logic [Q_W-1:0] ang_sq;
  } side_t;

  // (a*b + 2^29) >> 30
  function automatic logic [Q_W:0] mulq30(input logic [Q_W:0] a, input logic [Q_W:0] b);
    logic [2*Q_W+1:0] p;
    p = a * b + (62'd1 << (Q_W - 1));
    return p[2*Q_W:Q_W];
  endfunction

  // ------------------------------------------------------------------
  // Configuration registers
  // ------------------------------------------------------------------
  logic [LEN_W-1:0] length_r;
  logic             normalize_r;
  logic [LEN_W-1:0] len_clamp;
  logic             cfg_known;

  assign cfg_known = (cfg_index == REG_WINDOW_LENGTH) || (cfg_index == REG_NORMALIZE);

  always_comb begin
    if (cfg_wdata < LEN_W'(MIN_LENGTH)) begin
      len_clamp = LEN_W'(MIN_LENGTH);
    end else if (cfg_wdata > LEN_W'(MAX_LENGTH)) begin
      len_clamp = LEN_W'(MAX_LENGTH);
    end else begin
      len_clamp = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      length_r    <= LEN_W'(RESET_LENGTH);
      normalize_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WINDOW_LENGTH: length_r    <= len_clamp;
        REG_NORMALIZE:     normalize_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Reciprocal unit: restoring divider, one quotient bit per cycle.
  // First pass: phase_step = round(2^32 / (L-1)), keep low 32 bits.
  // Second pass: norm_scale = round(2^59 / sum), sum = 0.54*L - 0.46
  // (length two uses the true sum 0.16).
  // ------------------------------------------------------------------
  seq_state_t        state_r;
  logic              start_r;
  logic [CNT_W-1:0]  div_cnt_r;
  logic [DIV_W-1:0]  num_r;
  logic [SUM_W-1:0]  rem_r;
  logic [SUM_W-1:0]  den_r;
  logic [31:0]       phase_step_r;
  logic [31:0]       norm_scale_r;

  logic [LEN_W-2:0]  len_m1;
  logic [SUM_W:0]    sum_prod;
  logic [SUM_W-1:0]  win_sum;
  logic [DIV_W-1:0]  phase_num;
  logic [DIV_W-1:0]  norm_num;
  logic [SUM_W:0]    rem_sh;
  logic              rem_ge;
  logic [SUM_W-1:0]  rem_nxt;
  logic [DIV_W-1:0]  num_nxt;
  logic              div_last;
  logic              load_phase;
  logic              recalc_busy;

  assign len_m1    = (LEN_W - 1)'(length_r - LEN_W'(1));
  assign sum_prod  = (SUM_W + 1)'(COEF_A) * length_r;
  assign win_sum   = (length_r == LEN_W'(MIN_LENGTH)) ? SUM_TWO
                   : (sum_prod[SUM_W-1:0] - SUM_W'(COEF_B));
  assign phase_num = (DIV_W'(1) << 32) + DIV_W'(len_m1 >> 1);
  assign norm_num  = (DIV_W'(1) << NORM_SHIFT) + DIV_W'(win_sum >> 1);

  assign rem_sh    = {rem_r, num_r[DIV_W-1]};
  assign rem_ge    = rem_sh >= {1'b0, den_r};
  assign rem_nxt   = rem_ge ? SUM_W'(rem_sh - {1'b0, den_r}) : rem_sh[SUM_W-1:0];
  assign num_nxt   = {num_r[DIV_W-2:0], rem_ge};

  assign div_last    = div_cnt_r == DIV_LAST;
  assign load_phase  = (state_r == S_IDLE) && start_r;
  assign recalc_busy = start_r || (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      start_r   <= 1'b1;      // rebuild reciprocals for the reset length
      div_cnt_r <= '0;
    end else if (cfg_we && cfg_known) begin
      // a write to a known register index restarts the rebuild
      state_r   <= S_IDLE;
      start_r   <= 1'b1;
      div_cnt_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start_r) begin
            state_r   <= S_PHASE;
            start_r   <= 1'b0;
            div_cnt_r <= '0;
          end
        end
        S_PHASE: begin
          if (div_last) begin
            state_r   <= S_NORM;
            div_cnt_r <= '0;
          end else begin
            div_cnt_r <= div_cnt_r + CNT_W'(1);
          end
        end
        S_NORM: begin
          if (div_last) begin
            state_r <= S_IDLE;
          end else begin
            div_cnt_r <= div_cnt_r + CNT_W'(1);
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load_phase) begin
      num_r <= phase_num;
      rem_r <= '0;
      den_r <= SUM_W'(len_m1);
    end else if ((state_r == S_PHASE) && div_last) begin
      phase_step_r <= num_nxt[31:0];
      num_r        <= norm_num;
      rem_r        <= '0;
      den_r        <= win_sum;
    end else if ((state_r == S_NORM) && div_last) begin
      norm_scale_r <= num_nxt[31:0];
    end else if (state_r != S_IDLE) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
    end
  end

  // ------------------------------------------------------------------
  // Pipeline flow control: a stage moves when it is empty or the stage
  // after it moves, so bubbles close up and the input keeps flowing,
  // until the pipeline is full, while a finished word waits at the output.
  // ------------------------------------------------------------------
  logic [NSTG-1:0] valid_r;
  logic [NSTG-1:0] valid_nxt;
  logic [NSTG-1:0] adv;
  side_t           sb_r   [NSTG];
  side_t           sb_nxt [NSTG];
  logic            in_fire;

  assign adv[NSTG-1] = !valid_r[NSTG-1] || out_word.ready;
  for (genvar i = 0; i < NSTG - 1; i++) begin : g_adv
    assign adv[i] = !valid_r[i] || adv[i+1];
  end

  assign in_word.ready = adv[ST_IN] && !recalc_busy;
  assign in_fire       = in_word.valid && in_word.ready;

  assign valid_nxt[ST_IN] = in_fire;
  for (genvar i = 1; i < NSTG; i++) begin : g_vnxt
    assign valid_nxt[i] = valid_r[i-1];
  end

  for (genvar i = 0; i < NSTG; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[i] <= 1'b0;
      end else if (adv[i]) begin
        valid_r[i] <= valid_nxt[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv[i]) begin
        sb_r[i] <= sb_nxt[i];
      end
    end
  end

  // Stage 0: index register
  logic [IDX_W-1:0] idx_r;

  always_ff @(posedge clk) begin
    if (adv[ST_IN]) begin
      idx_r <= in_word.sample_index;
    end
  end

  // Stage 1: phase as a 32-bit fraction of a turn
  logic [IDX_W+31:0] ph_prod;
  logic [31:0]       ph_r;

  assign ph_prod = (IDX_W + 32)'(idx_r) * phase_step_r;

  always_ff @(posedge clk) begin
    if (adv[ST_PHASE]) begin
      ph_r <= ph_prod[31:0];
    end
  end

  // Stage 2: fold to [0, pi/4]; above an octant use the complement and swap sin/cos
  logic [Q_W-1:0] ph_rem;
  logic           ang_swap;
  logic [Q_W-1:0] ph_fold;
  logic [62:0]    ang_prod;

  assign ph_rem   = ph_r[Q_W-1:0];
  assign ang_swap = ph_rem > (Q_W'(1) << (Q_W - 1));
  assign ph_fold  = ang_swap ? Q_W'(Q30_ONE - {1'b0, ph_rem}) : ph_rem;
  assign ang_prod = ph_fold * HALF_PI_Q32 + (63'd1 << 31);

  // Stage 3: angle squared
  logic [Q_W:0] sq_full;

  assign sq_full = mulq30({1'b0, sb_r[ST_SQ-1].ang}, {1'b0, sb_r[ST_SQ-1].ang});

  always_comb begin
    sb_nxt[ST_IN]     = '0;
    sb_nxt[ST_IN].oor = {1'b0, in_word.sample_index} >= length_r;
    for (int i = 1; i < NSTG; i++) begin
      sb_nxt[i] = sb_r[i-1];
    end
    sb_nxt[ST_ANGLE].quad   = ph_r[31:30];
    sb_nxt[ST_ANGLE].swap   = ang_swap;
    sb_nxt[ST_ANGLE].ang    = ang_prod[62-1:32];
    sb_nxt[ST_SQ].ang_sq    = sq_full[Q_W-1:0];
  end

  // Stages 4..15: cos and sin series lanes.
  // t <- 1 - (x^2 * t) / d; the divide is an exact reciprocal multiply
  // since every dividend stays below 2^30.
  logic [Q_W-1:0] vc_r [SERIES_STEPS];
  logic [Q_W-1:0] vs_r [SERIES_STEPS];
  logic [Q_W:0]   tc_r [SERIES_STEPS];
  logic [Q_W:0]   ts_r [SERIES_STEPS];

  for (genvar i = 0; i < SERIES_STEPS; i++) begin : g_ser
    localparam int STA = ST_SER0 + 2 * i;
    localparam int STB = STA + 1;
    localparam int CK  = Q_W + $clog2(COS_DIV[i]);
    localparam int SK  = Q_W + $clog2(SIN_DIV[i]);
    localparam logic [Q_W:0] CM =
      (Q_W + 1)'(((64'd1 << CK) + 64'(COS_DIV[i]) - 64'd1) / 64'(COS_DIV[i]));
    localparam logic [Q_W:0] SM =
      (Q_W + 1)'(((64'd1 << SK) + 64'(SIN_DIV[i]) - 64'd1) / 64'(SIN_DIV[i]));

    logic [Q_W:0]   tc_prev;
    logic [Q_W:0]   ts_prev;
    logic [Q_W:0]   vc_full;
    logic [Q_W:0]   vs_full;
    logic [2*Q_W:0] qc_prod;
    logic [2*Q_W:0] qs_prod;
    logic [2*Q_W:0] qc_sh;
    logic [2*Q_W:0] qs_sh;

    if (i == 0) begin : g_first
      assign tc_prev = Q30_ONE;
      assign ts_prev = Q30_ONE;
    end else begin : g_next
      assign tc_prev = tc_r[i-1];
      assign ts_prev = ts_r[i-1];
    end

    assign vc_full = mulq30({1'b0, sb_r[STA-1].ang_sq}, tc_prev);
    assign vs_full = mulq30({1'b0, sb_r[STA-1].ang_sq}, ts_prev);

    always_ff @(posedge clk) begin
      if (adv[STA]) begin
        vc_r[i] <= vc_full[Q_W-1:0];
        vs_r[i] <= vs_full[Q_W-1:0];
      end
    end

    assign qc_prod = (2 * Q_W + 1)'(vc_r[i]) * CM;
    assign qs_prod = (2 * Q_W + 1)'(vs_r[i]) * SM;
    assign qc_sh   = qc_prod >> CK;
    assign qs_sh   = qs_prod >> SK;

    always_ff @(posedge clk) begin
      if (adv[STB]) begin
        tc_r[i] <= Q30_ONE - {1'b0, qc_sh[Q_W-1:0]};
        ts_r[i] <= Q30_ONE - {1'b0, qs_sh[Q_W-1:0]};
      end
    end
  end

  // Stage 16: sin = x * series
  logic [Q_W:0] sin_full;
  logic [Q_W:0] sin_r;
  logic [Q_W:0] cos_r;

  assign sin_full = mulq30({1'b0, sb_r[ST_SIN-1].ang}, ts_r[SERIES_STEPS-1]);

  always_ff @(posedge clk) begin
    if (adv[ST_SIN]) begin
      sin_r <= sin_full;
      cos_r <= tc_r[SERIES_STEPS-1];
    end
  end

  // Stage 17: unfold quadrant, 0.46 * |cos| rounded
  logic [Q_W:0]   ct;
  logic [Q_W:0]   st;
  logic [Q_W:0]   cos_mag;
  logic           cos_neg;
  logic [59:0]    mag_prod;
  logic [Q_W-1:0] mag_r;
  logic           neg_r;

  assign ct = sb_r[ST_MAG-1].swap ? sin_r : cos_r;
  assign st = sb_r[ST_MAG-1].swap ? cos_r : sin_r;

  always_comb begin
    case (sb_r[ST_MAG-1].quad)
      2'd0:    begin cos_neg = 1'b0; cos_mag = ct; end
      2'd1:    begin cos_neg = 1'b1; cos_mag = st; end
      2'd2:    begin cos_neg = 1'b1; cos_mag = ct; end
      default: begin cos_neg = 1'b0; cos_mag = st; end
    endcase
  end

  assign mag_prod = COEF_B * cos_mag + (60'd1 << (Q_W - 1));

  always_ff @(posedge clk) begin
    if (adv[ST_MAG]) begin
      mag_r <= mag_prod[59:Q_W];
      neg_r <= cos_neg;
    end
  end

  // Stage 18: window value, clamp at 1.0
  logic [Q_W:0] win_raw;
  logic [Q_W:0] win_r;

  assign win_raw = neg_r ? ({1'b0, COEF_A} + {1'b0, mag_r})
                         : ({1'b0, COEF_A} - {1'b0, mag_r});

  always_ff @(posedge clk) begin
    if (adv[ST_WIN]) begin
      win_r <= (win_raw > Q30_ONE) ? Q30_ONE : win_raw;
    end
  end

  // Stage 19: normalize, w * (1/sum in Q3.29), rounded, clamp at 1.0
  logic [62:0] nrm_prod;
  logic [33:0] nrm_q;
  logic [Q_W:0] nrm_r;

  assign nrm_prod = win_r * norm_scale_r + (63'd1 << 28);
  assign nrm_q    = nrm_prod[62:29];

  always_ff @(posedge clk) begin
    if (adv[ST_NORM]) begin
      if (!normalize_r) begin
        nrm_r <= win_r;
      end else if (nrm_q > 34'(Q30_ONE)) begin
        nrm_r <= Q30_ONE;
      end else begin
        nrm_r <= nrm_q[Q_W:0];
      end
    end
  end

  // Stage 20: output format, out-of-range words give zero
  logic [63:0]       frac_val;
  logic [COEF_W-1:0] frac_sat;
  logic [COEF_W-1:0] coef_r;

  assign frac_val = ((64'(nrm_r) + 64'(FRAC_RND)) >> DN_SH) << UP_SH;
  assign frac_sat = (frac_val > 64'(COEF_ONE)) ? COEF_ONE : frac_val[COEF_W-1:0];

  always_ff @(posedge clk) begin
    if (adv[ST_OUT]) begin
      coef_r <= sb_r[ST_OUT-1].oor ? '0 : frac_sat;
    end
  end

  assign out_word.valid              = valid_r[ST_OUT];
  assign out_word.coefficient        = coef_r;
  assign out_word.index_out_of_range = sb_r[ST_OUT].oor;

`ifndef ASSERT_OFF
  // No index word may enter while reciprocals are being rebuilt
  a_no_accept_in_recalc: assert property (@(posedge clk) disable iff (!rst_n)
    (start_r || (state_r != S_IDLE)) |-> !(in_word.valid && in_word.ready))
    else $error("index word accepted during reciprocal rebuild");

  // Out-of-range words carry a zero coefficient
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_word.valid && out_word.index_out_of_range) |-> (out_word.coefficient == '0))
    else $error("out-of-range word with nonzero coefficient");

  // Saturation keeps every coefficient at or below 1.0
  a_coef_le_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_word.valid |-> (out_word.coefficient <= COEF_ONE))
    else $error("coefficient above 1.0");
`endif

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking bench for the Hamming window generator: queued index words, scored coefficients.
module tb;
  import hwg_pkg::*;

  // Run shape
  localparam int LATENCY         = 20;
  localparam int DRAIN_CYCLES    = 2 * LATENCY;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int HOLD_LEN        = 300;   // long output stall, fills the pipeline
  localparam int HOLD_PHASE      = 4;
  localparam int RAND_PHASES     = 12;
  localparam int WORDS_PER_PHASE = 146;
  localparam int MAX_REPORTS     = 10;

  // Register indexes with no register behind them; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  // Phase table markers for randomly chosen settings
  localparam int LEN_RANDOM  = -1;
  localparam int LEN_SHORT   = -2;
  localparam int NORM_RANDOM = -1;

  // Fixed-point constants of the coefficient math, Q30 unless noted
  localparam logic [63:0] ONE_Q30   = 64'd1 << 30;
  localparam logic [63:0] K_HALF_PI = 64'd6746518852;  // pi/2 in Q32
  localparam logic [63:0] K_A       = 64'd579820585;   // 0.54
  localparam logic [63:0] K_B       = 64'd493921239;   // 0.46

  typedef struct packed {
    logic [COEF_W-1:0] coefficient;
    logic              index_out_of_range;
  } coef_word_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  hwg_in_if  in_if ();
  hwg_out_if out_if ();

  hamming_window_generator dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_if),
    .out_word (out_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Shadow of the block's registers and the reciprocals derived from them
  logic [LEN_W-1:0] win_len;
  logic             norm_on;
  logic [63:0]      phase_inc;   // 2^32/(length-1), rounded, mod 2^32
  logic [63:0]      recip_sum;   // 1/window sum in Q3.29

  logic [IDX_W-1:0] index_backlog [$];   // index words not yet offered
  coef_word_t       coef_expected [$];   // coefficients owed by the block

  int          src_idle_pct;
  int          snk_stall_pct;
  logic        hold_arm;
  int unsigned hold_left;
  int unsigned cycle_count;
  int unsigned words_sent;
  int unsigned words_checked;
  int unsigned mismatches;
  int unsigned reg_writes;

  // ---------------------------------------------------------------------------
  // Coefficient predictor
  // ---------------------------------------------------------------------------

  function automatic logic [63:0] mul_q30(input logic [63:0] a, input logic [63:0] b);
    return (a * b + (64'd1 << 29)) >> 30;
  endfunction

  // Horner-form Taylor series in x^2; odd selects the sine divisors
  function automatic logic [63:0] taylor_q30(input logic [63:0] x2, input logic odd);
    logic [63:0] t;
    logic [63:0] d;
    t = ONE_Q30;
    for (int i = 0; i < 6; i++) begin
      case (i)
        0: d = odd ? 64'd156 : 64'd132;
        1: d = odd ? 64'd110 : 64'd90;
        2: d = odd ? 64'd72  : 64'd56;
        3: d = odd ? 64'd42  : 64'd30;
        4: d = odd ? 64'd20  : 64'd12;
        default: d = odd ? 64'd6 : 64'd2;
      endcase
      t = ONE_Q30 - mul_q30(x2, t) / d;
    end
    return t;
  endfunction

  function automatic void rebuild_recips();
    logic [63:0] n1;
    logic [63:0] wsum;
    n1 = 64'(win_len) - 64'd1;
    phase_inc = (((64'd1 << 32) + n1 / 64'd2) / n1) & 64'hFFFF_FFFF;
    // the closed form breaks down at two points; the true sum 0.16 is used there
    wsum = (win_len == LEN_W'(MIN_LENGTH)) ? 64'd2 * (K_A - K_B) : K_A * 64'(win_len) - K_B;
    recip_sum = (((64'd1 << 59) + wsum / 64'd2) / wsum) & 64'hFFFF_FFFF;
  endfunction

  function automatic void model_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
    logic [63:0] v;
    case (idx)
      REG_WINDOW_LENGTH: begin
        v = 64'(data);
        if (v < 64'(MIN_LENGTH)) v = 64'(MIN_LENGTH);
        if (v > 64'(MAX_LENGTH)) v = 64'(MAX_LENGTH);
        win_len = LEN_W'(v);
        rebuild_recips();
      end
      REG_NORMALIZE: begin
        norm_on = data[0];
        rebuild_recips();
      end
      default: ;
    endcase
  endfunction

  function automatic coef_word_t hamming_coef(input logic [IDX_W-1:0] idx);
    coef_word_t  res;
    logic [63:0] p, r, x, x2, c, s, c_oct, s_oct, mag, m, w;
    logic        swap, neg;
    res.coefficient        = '0;
    res.index_out_of_range = 1'b1;
    if (64'(idx) >= 64'(win_len)) return res;
    // phase as a 32-bit fraction of a turn, folded to [0, pi/4]
    p = (64'(idx) * phase_inc) & 64'hFFFF_FFFF;
    r = {34'd0, p[29:0]};
    swap = r > (64'd1 << 29);
    if (swap) r = ONE_Q30 - r;
    x  = (r * K_HALF_PI + (64'd1 << 31)) >> 32;
    x2 = mul_q30(x, x);
    c  = taylor_q30(x2, 1'b0);
    s  = mul_q30(x, taylor_q30(x2, 1'b1));
    c_oct = swap ? s : c;
    s_oct = swap ? c : s;
    case (p[31:30])
      2'd0:    begin neg = 1'b0; mag = c_oct; end
      2'd1:    begin neg = 1'b1; mag = s_oct; end
      2'd2:    begin neg = 1'b1; mag = c_oct; end
      default: begin neg = 1'b0; mag = s_oct; end
    endcase
    m = (K_B * mag + (64'd1 << 29)) >> 30;
    w = neg ? K_A + m : K_A - m;
    if (w > ONE_Q30) w = ONE_Q30;
    if (norm_on) begin
      w = (w * recip_sum + (64'd1 << 28)) >> 29;
      if (w > ONE_Q30) w = ONE_Q30;
    end
    // Q30 down to the output format, rounded half up, saturated at 1.0
    w = (w + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
    if (w > (64'd1 << FRAC_BITS)) w = 64'd1 << FRAC_BITS;
    res.coefficient        = COEF_W'(w);
    res.index_out_of_range = 1'b0;
    return res;
  endfunction

  // Mostly indexes inside the window, some at its edge and some anywhere in 12 bits
  function automatic logic [IDX_W-1:0] pick_index();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 80)      return IDX_W'($urandom_range(32'(win_len) - 1));
    else if (roll < 85) return IDX_W'(32'(win_len) - 1);
    else if (roll < 90) return IDX_W'(win_len);
    else                return IDX_W'($urandom);
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, hold-off counter and run limit
  // ---------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Output stall counted here; armed for one cycle by the sequence below
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_arm) begin
      hold_left <= HOLD_LEN;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: offers backlog words; an accepted word books its coefficient
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        coef_expected.push_back(hamming_coef(in_if.sample_index));
        words_sent++;
      end
      // slot is free when nothing is offered or the offer was just taken
      if (!in_if.valid || in_if.ready) begin
        if (index_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          in_if.valid        <= 1'b1;
          in_if.sample_index <= index_backlog.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: scores each coefficient word against the oldest booking
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : score
    coef_word_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (coef_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected word: coefficient %h range %b",
                     out_if.coefficient, out_if.index_out_of_range);
        end else begin
          want = coef_expected.pop_front();
          words_checked++;
          if (out_if.coefficient !== want.coefficient ||
              out_if.index_out_of_range !== want.index_out_of_range) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("word %0d: coefficient %h range %b, wanted %h range %b",
                       words_checked - 1, out_if.coefficient, out_if.index_out_of_range,
                       want.coefficient, want.index_out_of_range);
          end
        end
      end
      out_if.ready <= (hold_left == 0) && ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  // One register write; after a write to a known index the block rebuilds its reciprocals and holds off input
  // until done, so wait for ready before anything else goes in.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    model_write(idx, data);
    reg_writes++;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    while (!in_if.ready) @(negedge clk);
  endtask

  // Idle means: backlog empty, nothing on offer, nothing owed
  task automatic drain();
    @(negedge clk);
    while (index_backlog.size() != 0 || in_if.valid || coef_expected.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    int len_val;
    int norm_val;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_wdata          = '0;
    in_if.valid        = 1'b0;
    in_if.sample_index = '0;
    out_if.ready       = 1'b0;
    hold_arm           = 1'b0;
    cycle_count        = 0;
    words_sent         = 0;
    words_checked      = 0;
    mismatches         = 0;
    reg_writes         = 0;
    src_idle_pct       = 0;
    snk_stall_pct      = 0;
    win_len            = LEN_W'(RESET_LENGTH);
    norm_on            = 1'b0;
    rebuild_recips();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    // reciprocal rebuild after reset keeps ready low for a while
    @(negedge clk);
    while (!in_if.ready) @(negedge clk);

    // --- directed words, no idling ---
    // reset settings: first two points, quarter, half, three quarters, last point, first outside, top index
    index_backlog.push_back(12'd0);    index_backlog.push_back(12'd1);
    index_backlog.push_back(12'd64);   index_backlog.push_back(12'd128);
    index_backlog.push_back(12'd192);  index_backlog.push_back(12'd255);
    index_backlog.push_back(12'd256);  index_backlog.push_back(12'd4095);
    drain();
    // length nine: phase steps land exactly on octant and quadrant edges
    write_reg(REG_WINDOW_LENGTH, 13'd9);
    index_backlog.push_back(12'd1);    index_backlog.push_back(12'd2);
    index_backlog.push_back(12'd4);    index_backlog.push_back(12'd6);
    index_backlog.push_back(12'd8);
    drain();
    // length below two is taken as two; the step wraps to zero
    write_reg(REG_WINDOW_LENGTH, 13'd0);
    index_backlog.push_back(12'd0);    index_backlog.push_back(12'd1);
    index_backlog.push_back(12'd2);
    drain();
    // oversized length saturates; normalize from an all-ones word
    write_reg(REG_WINDOW_LENGTH, 13'h1FFF);
    write_reg(REG_NORMALIZE, 13'h1FFF);
    index_backlog.push_back(12'd0);    index_backlog.push_back(12'd2048);
    index_backlog.push_back(12'd4095);
    drain();
    // only bit 0 of normalize counts; writes to spare indexes change nothing
    write_reg(REG_NORMALIZE, 13'h1FFE);
    write_reg(REG_SPARE_2, 13'd5);
    write_reg(REG_SPARE_3, 13'h1FFF);
    index_backlog.push_back(12'd4095); index_backlog.push_back(12'd1);
    drain();
    // three points, normalized
    write_reg(REG_WINDOW_LENGTH, 13'd3);
    write_reg(REG_NORMALIZE, 13'd1);
    index_backlog.push_back(12'd1);    index_backlog.push_back(12'd2);
    index_backlog.push_back(12'd3);

    // --- random phases: settings and idling mix change per phase ---
    for (int p = 0; p < RAND_PHASES; p++) begin
      drain();
      case (p % 4)
        0:       begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1:       begin src_idle_pct = 66; snk_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  snk_stall_pct = 66; end
        default: begin src_idle_pct = 23; snk_stall_pct = 23; end
      endcase
      case (p)
        0:       begin len_val = 256;        norm_val = 0;           end
        1:       begin len_val = 4096;       norm_val = 1;           end
        2:       begin len_val = 1;          norm_val = 0;           end
        3:       begin len_val = 3;          norm_val = 1;           end
        4:       begin len_val = 5000;       norm_val = 0;           end
        5:       begin len_val = LEN_RANDOM; norm_val = 1;           end
        6:       begin len_val = LEN_SHORT;  norm_val = NORM_RANDOM; end
        7:       begin len_val = 1000;       norm_val = 1;           end
        8:       begin len_val = LEN_RANDOM; norm_val = NORM_RANDOM; end
        9:       begin len_val = 4095;       norm_val = 1;           end
        10:      begin len_val = LEN_RANDOM; norm_val = NORM_RANDOM; end
        default: begin len_val = 2;          norm_val = 1;           end
      endcase
      // a random length is sometimes a raw 13-bit word, so clamping gets hit too
      if (len_val == LEN_RANDOM)
        len_val = ($urandom_range(3) == 0) ? int'($urandom_range(8191))
                                           : int'($urandom_range(4096, 2));
      else if (len_val == LEN_SHORT)
        len_val = int'($urandom_range(40, 2));
      if (norm_val == NORM_RANDOM) norm_val = int'($urandom_range(8191));
      write_reg(REG_WINDOW_LENGTH, CFG_DATA_W'(len_val));
      write_reg(REG_NORMALIZE, CFG_DATA_W'(norm_val));
      for (int k = 0; k < WORDS_PER_PHASE; k++) index_backlog.push_back(pick_index());
      // sender keeps offering while the output side is held off
      if (p == HOLD_PHASE) begin
        @(posedge clk);
        hold_arm <= 1'b1;
        @(posedge clk);
        hold_arm <= 1'b0;
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d index words and %0d register writes: lengths 2 to %0d, clamped lengths,",
             words_sent, reg_writes, MAX_LENGTH);
    $display("normalize on/off, out-of-range indexes, four idling mixes, one long output stall.");
    $display("%0d coefficient words checked, %0d mismatches.", words_checked, mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
